// ===== rtl/prts_pkg.sv =====
// shared types and defaults for the priority round robin task scheduler
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package prts_pkg;

  localparam int NumTasksDef  = 32;
  localparam int NumLevelsDef = 64;
  localparam int TickBitsDef  = 32;

  // input word field widths
  localparam int KindW   = 3;
  localparam int IdW     = 5;
  localparam int PrioW   = 6;
  localparam int FieldTW = 32;
  localparam int InDataW  = 80;
  localparam int OutDataW = 40;

  typedef enum logic [KindW-1:0] {
    K_CREATE = 3'd0,
    K_SETP   = 3'd1,
    K_SCHED  = 3'd2,
    K_SLEEP  = 3'd3,
    K_WAKE   = 3'd4
  } kind_t;

  typedef enum logic [1:0] {
    ST_NONE    = 2'd0,
    ST_READY   = 2'd1,
    ST_RUNNING = 2'd2,
    ST_WAITING = 2'd3
  } status_t;

endpackage
`default_nettype wire

// ===== rtl/prts_ram.sv =====
// generic single write port ram with registered read
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
module prts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [0:DEPTH-1];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== rtl/priority_round_robin_task_scheduler_unit.sv =====
// top level of the priority round robin task scheduler
// uses prts_pkg and three prts_ram instances (levels, links, task table)
//
// channel  dir  tvalid/tready        tdata / tuser
// in_      in   in_tvalid/in_tready  one command word, kind in tuser
// out_     out  out_tvalid/out_tready one result word per command
//
// one command at a time through a sequencer; the path of each word is set by the
// read-modify-write of the task table, the level table and the link table
// rst_n clears the sequencer, ready bitmap, task status, period valid bits and current task
// a command is taken while the previous result still waits; the sequencer holds
// in its last state until the output register is free
`timescale 1ns / 1ps
`default_nettype none
module priority_round_robin_task_scheduler_unit #(
  parameter int NUM_TASKS  = prts_pkg::NumTasksDef,
  parameter int NUM_LEVELS = prts_pkg::NumLevelsDef,
  parameter int TICK_BITS  = prts_pkg::TickBitsDef
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_tvalid,
  output logic                               in_tready,
  // task_id[4:0], priority_req[10:5], period[42:11], now_tick[74:43]
  input  wire logic [prts_pkg::InDataW-1:0]  in_tdata,
  // kind[2:0]
  input  wire logic [prts_pkg::KindW-1:0]    in_tuser,
  output logic                               out_tvalid,
  input  wire logic                          out_tready,
  // running_task[4:0], running_valid[5], wake_time[37:6], no_ready_error[38]
  output logic [prts_pkg::OutDataW-1:0]      out_tdata
);

  localparam int TW = $clog2(NUM_TASKS);
  localparam int LW = $clog2(NUM_LEVELS);
  localparam int TB = TICK_BITS;
  localparam int TRW = LW + 2 * TB;

  typedef enum logic [3:0] {
    S_IDLE, S_T_RD, S_T_WR, S_ENQ_RD, S_ENQ_WR,
    S_DEQ_RD, S_DEQ_WT, S_DEQ_HD, S_DEQ_LW, S_DEQ_LK, S_DONE
  } state_t;

  state_t                state_r;
  logic                  is_create_r, is_setp_r, is_sleep_r;
  logic [TW-1:0]         t_r, cur_r, h_r, tail_r;
  logic                  cur_valid_r;
  logic [LW-1:0]         lvl_r;
  logic [LW-1:0]         prio_sat_r;
  logic [TB-1:0]         period_r, tick_r, wake_r;
  logic                  enq_r, deq_r, err_r;
  logic [NUM_LEVELS-1:0] bitmap_r;
  prts_pkg::status_t     status_r [0:NUM_TASKS-1];
  logic [NUM_TASKS-1:0]  pv_r;
  logic                  out_valid_r;
  logic [prts_pkg::OutDataW-1:0] out_data_r;

  // input fields
  logic [prts_pkg::IdW-1:0]   in_id;
  logic [prts_pkg::PrioW-1:0] in_prio;
  logic [TW-1:0]              id_t;
  logic                       id_ok;
  logic [LW-1:0]              prio_sat;
  assign in_id   = in_tdata[4:0];
  assign in_prio = in_tdata[10:5];
  assign id_t    = TW'(in_id);
  assign id_ok   = 32'(in_id) < 32'(NUM_TASKS);
  assign prio_sat = (32'(in_prio) > 32'(NUM_LEVELS - 1)) ? LW'(NUM_LEVELS - 1) : LW'(in_prio);

  // ram ports
  logic                 lv_we, lk_we, tk_we;
  logic [2*TW-1:0]      lv_wdata, lv_rdata;
  logic [TW-1:0]        lk_waddr, lk_rdata;
  logic [TRW-1:0]       tk_wdata, tk_rdata;

  prts_ram #(.WIDTH(2*TW), .DEPTH(NUM_LEVELS)) u_level_ram (
    .clk(clk), .we(lv_we), .waddr(lvl_r), .wdata(lv_wdata), .raddr(lvl_r), .rdata(lv_rdata)
  );
  prts_ram #(.WIDTH(TW), .DEPTH(NUM_TASKS)) u_link_ram (
    .clk(clk), .we(lk_we), .waddr(lk_waddr), .wdata(t_r), .raddr(h_r), .rdata(lk_rdata)
  );
  prts_ram #(.WIDTH(TRW), .DEPTH(NUM_TASKS)) u_task_ram (
    .clk(clk), .we(tk_we), .waddr(t_r), .wdata(tk_wdata), .raddr(t_r), .rdata(tk_rdata)
  );

  // task table word: prio, period, last ready tick
  logic [LW-1:0] old_prio;
  logic [TB-1:0] old_period, old_tick;
  logic [TW-1:0] lv_head, lv_tail;
  logic [LW-1:0] ff_lvl;
  assign old_prio   = tk_rdata[TRW-1 -: LW];
  assign old_period = pv_r[t_r] ? tk_rdata[2*TB-1 -: TB] : '0;
  assign old_tick   = tk_rdata[TB-1:0];
  assign lv_head    = lv_rdata[2*TW-1 -: TW];
  assign lv_tail    = lv_rdata[TW-1:0];

  always_comb begin
    ff_lvl = '0;
    for (int i = NUM_LEVELS - 1; i >= 0; i--) begin
      if (bitmap_r[i]) ff_lvl = LW'(i);
    end
  end

  always_comb begin
    tk_we    = (state_r == S_T_WR) && !is_sleep_r;
    tk_wdata = {is_create_r ? prio_sat_r : old_prio,
                is_setp_r ? period_r : old_period,
                is_setp_r ? old_tick : tick_r};
    lv_we    = 1'b0;
    lv_wdata = {t_r, t_r};
    lk_we    = 1'b0;
    lk_waddr = lv_tail;
    case (state_r)
      S_ENQ_WR: begin
        lv_we = 1'b1;
        if (bitmap_r[lvl_r]) begin
          lk_we    = 1'b1;
          lv_wdata = {lv_head, t_r};
        end
      end
      S_DEQ_LK: begin
        lv_we    = 1'b1;
        lv_wdata = {lk_rdata, tail_r};
      end
      default: ;
    endcase
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cur_r       <= '0;
      cur_valid_r <= 1'b0;
      bitmap_r    <= '0;
      pv_r        <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < NUM_TASKS; i++) status_r[i] <= prts_pkg::ST_NONE;
    end else begin
      // in S_DONE the output register is always reloaded when it drains
      if (out_valid_r && out_tready && state_r != S_DONE) out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            is_create_r <= 1'b0;
            is_setp_r   <= 1'b0;
            is_sleep_r  <= 1'b0;
            enq_r       <= 1'b0;
            deq_r       <= 1'b0;
            err_r       <= 1'b0;
            wake_r      <= '0;
            prio_sat_r  <= prio_sat;
            period_r    <= TB'(in_tdata[42:11]);
            tick_r      <= TB'(in_tdata[74:43]);
            state_r     <= S_DONE;
            case (in_tuser)
              prts_pkg::K_CREATE: begin
                if (id_ok && status_r[id_t] != prts_pkg::ST_READY &&
                    status_r[id_t] != prts_pkg::ST_RUNNING) begin
                  status_r[id_t] <= prts_pkg::ST_READY;
                  t_r <= id_t;
                  is_create_r <= 1'b1;
                  enq_r <= 1'b1;
                  state_r <= S_T_RD;
                end
              end
              prts_pkg::K_SETP: begin
                if (id_ok) begin
                  t_r <= id_t;
                  is_setp_r <= 1'b1;
                  state_r <= S_T_RD;
                end
              end
              prts_pkg::K_SCHED: begin
                deq_r <= 1'b1;
                if (cur_valid_r && status_r[cur_r] == prts_pkg::ST_RUNNING) begin
                  status_r[cur_r] <= prts_pkg::ST_READY;
                  t_r <= cur_r;
                  enq_r <= 1'b1;
                  state_r <= S_T_RD;
                end else begin
                  state_r <= S_DEQ_RD;
                end
              end
              prts_pkg::K_SLEEP: begin
                deq_r <= 1'b1;
                if (cur_valid_r) begin
                  status_r[cur_r] <= prts_pkg::ST_WAITING;
                  t_r <= cur_r;
                  is_sleep_r <= 1'b1;
                  state_r <= S_T_RD;
                end else begin
                  state_r <= S_DEQ_RD;
                end
              end
              prts_pkg::K_WAKE: begin
                if (id_ok && status_r[id_t] == prts_pkg::ST_WAITING) begin
                  status_r[id_t] <= prts_pkg::ST_READY;
                  t_r <= id_t;
                  enq_r <= 1'b1;
                  state_r <= S_T_RD;
                end
              end
              default: ;
            endcase
          end
        end
        S_T_RD: state_r <= S_T_WR;
        S_T_WR: begin
          if (is_sleep_r) begin
            wake_r <= old_period + old_tick;
          end else begin
            pv_r[t_r] <= 1'b1;
          end
          lvl_r   <= is_create_r ? prio_sat_r : old_prio;
          state_r <= enq_r ? S_ENQ_RD : (deq_r ? S_DEQ_RD : S_DONE);
        end
        S_ENQ_RD: state_r <= S_ENQ_WR;
        S_ENQ_WR: begin
          bitmap_r[lvl_r] <= 1'b1;
          state_r <= deq_r ? S_DEQ_RD : S_DONE;
        end
        S_DEQ_RD: begin
          if (bitmap_r == '0) begin
            err_r   <= 1'b1;
            state_r <= S_DONE;
          end else begin
            lvl_r   <= ff_lvl;
            state_r <= S_DEQ_WT;
          end
        end
        S_DEQ_WT: state_r <= S_DEQ_HD;
        S_DEQ_HD: begin
          cur_r       <= lv_head;
          cur_valid_r <= 1'b1;
          status_r[lv_head] <= prts_pkg::ST_RUNNING;
          h_r    <= lv_head;
          tail_r <= lv_tail;
          if (lv_head == lv_tail) begin
            bitmap_r[lvl_r] <= 1'b0;
            state_r <= S_DONE;
          end else begin
            state_r <= S_DEQ_LW;
          end
        end
        S_DEQ_LW: state_r <= S_DEQ_LK;
        S_DEQ_LK: state_r <= S_DONE;
        S_DONE: begin
          if (!out_valid_r || out_tready) begin
            out_valid_r <= 1'b1;
            out_data_r  <= {1'b0, err_r, 32'(wake_r), cur_valid_r,
                            prts_pkg::IdW'(cur_r)};
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_valid_sticks: assert property (@(posedge clk) disable iff (!rst_n)
    cur_valid_r |=> cur_valid_r) else $error("running valid dropped");
  a_enq_sets_ready: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_ENQ_WR |=> bitmap_r[$past(lvl_r)]) else $error("enqueue left level empty");
  a_cur_created: assert property (@(posedge clk) disable iff (!rst_n)
    (cur_valid_r && state_r == S_IDLE) |-> status_r[cur_r] != prts_pkg::ST_NONE)
    else $error("current task never created");
  a_err_keeps_cur: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DEQ_RD && bitmap_r == '0) |=> $stable(cur_r))
    else $error("current task changed with no ready task");
`endif

endmodule
`default_nettype wire
